[hdl/nnrot_pkg.sv]
// nnrot_pkg: shared types, sizes and codes for the nearest-neighbour rotation core
// no dependencies; imported by every other file of the block

package nnrot_pkg;

  // frame store geometry
  localparam int unsigned MAX_ROWS   = 256;
  localparam int unsigned MAX_COLS   = 256;
  localparam int unsigned PIXEL_BITS = 16;

  localparam int unsigned ROW_IDX_W = $clog2(MAX_ROWS);
  localparam int unsigned COL_IDX_W = $clog2(MAX_COLS);
  localparam int unsigned MEM_DEPTH = MAX_ROWS * MAX_COLS;
  localparam int unsigned ADDR_W    = $clog2(MEM_DEPTH);

  // field widths
  localparam int unsigned COORD_W = 8;
  localparam int unsigned VALUE_W = 16;
  localparam int unsigned DIM_W   = 9;
  localparam int unsigned TRIG_W  = 16;

  // mapping arithmetic
  localparam int unsigned FRAC_W   = 14;
  localparam int unsigned SHIFT_W  = FRAC_W + 1;
  localparam int unsigned HALF_W   = COORD_W + 2;
  localparam int unsigned PROD_W   = HALF_W + TRIG_W;
  localparam int unsigned SUM_W    = PROD_W + 2;
  localparam int unsigned SRC_W    = SUM_W - SHIFT_W;

  // queue between front and back
  localparam int unsigned QUEUE_DEPTH = 8;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned OCC_W       = QCNT_W + 1;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COS  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SIN  = 2'd3;

  // item kinds
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef struct packed {
    logic [DIM_W-1:0]         rows;
    logic [DIM_W-1:0]         cols;
    logic signed [TRIG_W-1:0] cos_q;
    logic signed [TRIG_W-1:0] sin_q;
  } cfg_t;

  // one classified operation for the back end
  typedef struct packed {
    logic                  is_query;
    logic                  in_frame;
    logic [ADDR_W-1:0]     addr;
    logic [PIXEL_BITS-1:0] data;
  } op_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input int unsigned lim);
    logic [DIM_W-1:0] r;
    r = v;
    if (v > lim) begin
      r = DIM_W'(lim);
    end
    return r;
  endfunction

endpackage

[hdl/nnrot_if.sv]
// nnrot_if: valid/ready channel interfaces for input items and result words
// depends on nnrot_pkg

interface nnrot_in_if
  import nnrot_pkg::*;
  ();
  logic               valid;
  logic               ready;
  logic               kind;
  logic [COORD_W-1:0] row;
  logic [COORD_W-1:0] col;
  logic [VALUE_W-1:0] value;

  modport source (output valid, kind, row, col, value, input ready);
  modport sink   (input valid, kind, row, col, value, output ready);
endinterface

interface nnrot_out_if
  import nnrot_pkg::*;
  ();
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] pixel;
  logic               inside_res;

  modport source (output valid, pixel, inside_res, input ready);
  modport sink   (input valid, pixel, inside_res, output ready);
endinterface

[hdl/nearest_neighbour_image_rotation_core.sv]
// nearest_neighbour_image_rotation_core: frame store with rotated nearest-neighbour readout
// a query word passes the three front stages, the op queue and the output register before it is valid
// throughput: one item per cycle unless the result side stalls; the three-stage front and the single
// memory port of the back each handle one item a cycle, an 8-deep queue decouples them
// reset: control and configuration registers cleared to defaults; frame store not cleared
// depends on nnrot_pkg, nnrot_if, nnrot_front, nnrot_queue, nnrot_back

module nearest_neighbour_image_rotation_core
  import nnrot_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  nnrot_in_if.sink              in_i,
  nnrot_out_if.source           out_o
);

  cfg_t              cfg_q;
  logic              push;
  op_t               push_op;
  logic              q_valid;
  op_t               q_op;
  logic              q_pop;
  logic [QCNT_W-1:0] q_count;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rows  <= clamp_dim(DIM_W'(256), MAX_ROWS);
      cfg_q.cols  <= clamp_dim(DIM_W'(256), MAX_COLS);
      cfg_q.cos_q <= TRIG_W'(16384);
      cfg_q.sin_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_ROWS: cfg_q.rows  <= clamp_dim(cfg_data_i[DIM_W-1:0], MAX_ROWS);
        CFG_COLS: cfg_q.cols  <= clamp_dim(cfg_data_i[DIM_W-1:0], MAX_COLS);
        CFG_COS:  cfg_q.cos_q <= $signed(cfg_data_i[TRIG_W-1:0]);
        CFG_SIN:  cfg_q.sin_q <= $signed(cfg_data_i[TRIG_W-1:0]);
        default: ;
      endcase
    end
  end

  nnrot_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .queue_count_i (q_count),
    .in_i          (in_i),
    .push_o        (push),
    .op_o          (push_op)
  );

  nnrot_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .op_i    (push_op),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .op_o    (q_op),
    .count_o (q_count)
  );

  nnrot_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_valid_i (q_valid),
    .op_i       (q_op),
    .pop_o      (q_pop),
    .out_o      (out_o)
  );

  // queue never overflows thanks to the credit check in the front
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_count == QCNT_W'(QUEUE_DEPTH)) |-> !push || q_pop)
    else $error("op queue overflow");

  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid)
    else $error("pop from empty op queue");

  // a new result word always comes from a query taken off the queue
  a_word_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> $past(q_pop && q_op.is_query))
    else $error("result word without a query");

endmodule

[hdl/nnrot_front.sv]
// nnrot_front: accepts items, maps query coordinates back to the source pixel
// and classifies each item into a memory write or read; depends on nnrot_pkg, nnrot_if

module nnrot_front
  import nnrot_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfg_t              cfg_i,
  input  logic [QCNT_W-1:0] queue_count_i,
  nnrot_in_if.sink          in_i,
  output logic              push_o,
  output op_t               op_o
);

  // stage 1: half-pixel offsets
  logic                      s1_valid_q, s1_valid_d;
  logic                      s1_kind_q, s1_wr_ok_q;
  logic signed [HALF_W-1:0]  s1_x2_q, s1_y2_q;
  logic [ADDR_W-1:0]         s1_addr_q;
  logic [PIXEL_BITS-1:0]     s1_data_q;

  // stage 2: products
  logic                      s2_valid_q;
  logic                      s2_kind_q, s2_wr_ok_q;
  logic signed [PROD_W-1:0]  s2_xc_q, s2_ys_q, s2_xs_q, s2_yc_q;
  logic [ADDR_W-1:0]         s2_addr_q;
  logic [PIXEL_BITS-1:0]     s2_data_q;

  // stage 3: classified op
  logic                      s3_valid_q, s3_valid_d;
  op_t                       s3_op_q, s3_op_d;

  logic                      accept;
  logic [OCC_W-1:0]          occupancy;

  logic signed [SUM_W-1:0]   ncol, nrow, off_col, off_row;
  logic                      col_neg, row_neg, col_ok, row_ok, src_inside;
  logic [SRC_W-1:0]          src_col, src_row;

  // credit: every item in flight has a queue slot reserved
  assign occupancy = OCC_W'(queue_count_i) + OCC_W'(s1_valid_q) + OCC_W'(s2_valid_q)
                   + OCC_W'(s3_valid_q);
  assign in_i.ready = occupancy < OCC_W'(QUEUE_DEPTH);
  assign accept     = in_i.valid && in_i.ready;
  assign s1_valid_d = accept;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_kind_q  <= in_i.kind;
      s1_wr_ok_q <= (in_i.row < cfg_i.rows) && (in_i.col < cfg_i.cols);
      s1_x2_q    <= $signed({1'b0, in_i.col, 1'b0}) - $signed({1'b0, cfg_i.cols});
      s1_y2_q    <= $signed({1'b0, in_i.row, 1'b0}) - $signed({1'b0, cfg_i.rows});
      s1_addr_q  <= ADDR_W'(in_i.row) * ADDR_W'(MAX_COLS) + ADDR_W'(in_i.col);
      s1_data_q  <= in_i.value[PIXEL_BITS-1:0];
    end
    s2_kind_q  <= s1_kind_q;
    s2_wr_ok_q <= s1_wr_ok_q;
    s2_xc_q    <= PROD_W'(s1_x2_q) * PROD_W'(cfg_i.cos_q);
    s2_ys_q    <= PROD_W'(s1_y2_q) * PROD_W'(cfg_i.sin_q);
    s2_xs_q    <= PROD_W'(s1_x2_q) * PROD_W'(cfg_i.sin_q);
    s2_yc_q    <= PROD_W'(s1_y2_q) * PROD_W'(cfg_i.cos_q);
    s2_addr_q  <= s1_addr_q;
    s2_data_q  <= s1_data_q;
    s3_op_q    <= s3_op_d;
  end

  // centre offset: dimension times one half, in Q.15 of a pixel
  assign off_col = $signed(SUM_W'(cfg_i.cols) << FRAC_W);
  assign off_row = $signed(SUM_W'(cfg_i.rows) << FRAC_W);
  assign ncol    = SUM_W'(s2_xc_q) + SUM_W'(s2_ys_q) + off_col;
  assign nrow    = SUM_W'(s2_yc_q) - SUM_W'(s2_xs_q) + off_row;

  // truncation toward zero: a value in (-1, 0) still maps to index 0
  assign col_neg = ncol[SUM_W-1];
  assign row_neg = nrow[SUM_W-1];
  assign col_ok  = !col_neg || ((&ncol[SUM_W-1:SHIFT_W]) && (|ncol[SHIFT_W-1:0]));
  assign row_ok  = !row_neg || ((&nrow[SUM_W-1:SHIFT_W]) && (|nrow[SHIFT_W-1:0]));
  assign src_col = col_neg ? '0 : ncol[SUM_W-1:SHIFT_W];
  assign src_row = row_neg ? '0 : nrow[SUM_W-1:SHIFT_W];
  assign src_inside = col_ok && row_ok && (src_col < SRC_W'(cfg_i.cols))
                   && (src_row < SRC_W'(cfg_i.rows));

  always_comb begin
    s3_op_d.is_query = (s2_kind_q == KIND_QUERY);
    s3_op_d.in_frame = src_inside;
    s3_op_d.data     = s2_data_q;
    if (s2_kind_q == KIND_QUERY) begin
      s3_op_d.addr = ADDR_W'(src_row[ROW_IDX_W-1:0]) * ADDR_W'(MAX_COLS)
                   + ADDR_W'(src_col[COL_IDX_W-1:0]);
    end else begin
      s3_op_d.addr = s2_addr_q;
    end
  end

  // out-of-frame writes are dropped here
  assign s3_valid_d = s2_valid_q && ((s2_kind_q == KIND_QUERY) || s2_wr_ok_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s3_valid_d;
    end
  end

  assign push_o = s3_valid_q;
  assign op_o   = s3_op_q;

endmodule

[hdl/nnrot_queue.sv]
// nnrot_queue: short fifo of classified ops between front and back
// depends on nnrot_pkg

module nnrot_queue
  import nnrot_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  op_t               op_i,
  input  logic              pop_i,
  output logic              valid_o,
  output op_t               op_o,
  output logic [QCNT_W-1:0] count_o
);

  op_t               slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q, count_d;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= op_i;
    end
  end

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + QCNT_W'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
      end
      count_q <= count_d;
    end
  end

  assign valid_o = (count_q != '0);
  assign op_o    = slot_q[rd_ptr_q];
  assign count_o = count_q;

endmodule

[hdl/nnrot_back.sv]
// nnrot_back: frame store and output register; carries out writes and reads
// depends on nnrot_pkg, nnrot_if

module nnrot_back
  import nnrot_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       op_valid_i,
  input  op_t        op_i,
  output logic       pop_o,
  nnrot_out_if.source out_o
);

  logic [PIXEL_BITS-1:0] mem_q [MEM_DEPTH];
  logic [PIXEL_BITS-1:0] rd_q;
  logic                  inside_q;
  logic                  out_valid_q, out_valid_d;
  logic                  out_free;
  logic                  take_query;

  // writes never wait for the output side
  assign out_free   = !out_valid_q || out_o.ready;
  assign pop_o      = op_valid_i && (!op_i.is_query || out_free);
  assign take_query = pop_o && op_i.is_query;

  always_ff @(posedge clk_i) begin
    if (pop_o && !op_i.is_query) begin
      mem_q[op_i.addr] <= op_i.data;
    end
    if (take_query && op_i.in_frame) begin
      rd_q <= mem_q[op_i.addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_query) begin
      inside_q <= op_i.in_frame;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (take_query) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.inside_res = inside_q;
  assign out_o.pixel      = inside_q ? VALUE_W'(rd_q) : '0;

endmodule

[tb/sv/nnrot_rotation_monitor.sv]
`timescale 1ns / 1ps
// nnrot_rotation_monitor: watches the config port and both channels of the rotation core,
// keeps its own frame copy and geometry, predicts every query word and compares in order
// depends on nnrot_pkg and nnrot_if

module nnrot_rotation_monitor
  import nnrot_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  nnrot_in_if                   in_mon,
  nnrot_out_if                  out_mon,
  output int unsigned           fail_count_o,
  output int unsigned           pending_o
);

  typedef struct packed {
    logic [VALUE_W-1:0] pixel;
    logic               in_frame;
  } rot_word_t;

  cfg_t                  geom;
  logic [PIXEL_BITS-1:0] frame_mirror [MEM_DEPTH];
  rot_word_t             expected_words [$];
  int unsigned           mismatches;

  function automatic longint used_rows();
    return (geom.rows > MAX_ROWS) ? longint'(MAX_ROWS) : longint'(geom.rows);
  endfunction

  function automatic longint used_cols();
    return (geom.cols > MAX_COLS) ? longint'(MAX_COLS) : longint'(geom.cols);
  endfunction

  // inverse mapping of an output pixel back into the frame, offsets in half pixels
  function automatic rot_word_t rotate_lookup(input logic [COORD_W-1:0] row,
                                              input logic [COORD_W-1:0] col);
    longint    nr;
    longint    nc;
    longint    x2;
    longint    y2;
    longint    src_c;
    longint    src_r;
    longint    cq;
    longint    sq;
    rot_word_t w;
    nr = used_rows();
    nc = used_cols();
    cq = longint'($signed(geom.cos_q));
    sq = longint'($signed(geom.sin_q));
    x2 = 2 * longint'(col) - nc;
    y2 = 2 * longint'(row) - nr;
    // signed division truncates toward zero, so minus a half lands on 0
    src_c = (x2 * cq + y2 * sq + (nc <<< FRAC_W)) / (longint'(1) <<< SHIFT_W);
    src_r = (y2 * cq - x2 * sq + (nr <<< FRAC_W)) / (longint'(1) <<< SHIFT_W);
    w = '0;
    if (src_r >= 0 && src_r < nr && src_c >= 0 && src_c < nc) begin
      w.in_frame = 1'b1;
      w.pixel    = VALUE_W'(frame_mirror[src_r * MAX_COLS + src_c]);
    end
    return w;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    mismatches++;
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    rot_word_t want;
    if (!rst_ni) begin
      geom         = '{rows: 9'd256, cols: 9'd256, cos_q: 16'sd16384, sin_q: '0};
      expected_words.delete();
      mismatches   = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_ROWS: geom.rows  = cfg_data_i[DIM_W-1:0];
          CFG_COLS: geom.cols  = cfg_data_i[DIM_W-1:0];
          CFG_COS:  geom.cos_q = cfg_data_i[TRIG_W-1:0];
          CFG_SIN:  geom.sin_q = cfg_data_i[TRIG_W-1:0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.kind == KIND_WRITE) begin
          // writes outside the frame in use are dropped
          if (longint'(in_mon.row) < used_rows() && longint'(in_mon.col) < used_cols()) begin
            frame_mirror[int'(in_mon.row) * MAX_COLS + int'(in_mon.col)] =
              in_mon.value[PIXEL_BITS-1:0];
          end
        end else begin
          expected_words.push_back(rotate_lookup(in_mon.row, in_mon.col));
        end
      end
      if (out_mon.valid && out_mon.ready) begin
        if (expected_words.size() == 0) begin
          report_mismatch("unexpected word, pixel", out_mon.pixel, 0);
        end else begin
          want = expected_words.pop_front();
          if (out_mon.pixel !== want.pixel) begin
            report_mismatch("pixel", out_mon.pixel, want.pixel);
          end
          if (out_mon.inside_res !== want.in_frame) begin
            report_mismatch("inside_res", out_mon.inside_res, want.in_frame);
          end
        end
      end
      fail_count_o <= mismatches;
      pending_o    <= expected_words.size();
    end
  end

endmodule

[tb/sv/tb_nearest_neighbour_image_rotation_core.sv]
`timescale 1ns / 1ps
// tb_nearest_neighbour_image_rotation_core: stimulus and verdict for the rotation core
// writes pixels and queries rotated ones under several geometries; checking sits in
// nnrot_rotation_monitor; depends on nnrot_pkg, nnrot_if and the core

module tb_nearest_neighbour_image_rotation_core;
  import nnrot_pkg::*;

  localparam int LONG_HOLD       = 120;
  localparam int DRAIN_CYCLES    = 24;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int PHASES          = 12;
  localparam int ITEMS_PER_PHASE = 110;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int unsigned           fail_count;
  int unsigned           pending_words;
  int unsigned           quiet_cycles = 0;

  // geometry as last written, for steering queries away from unwritten pixels
  logic [DIM_W-1:0] geo_rows = 9'd256;
  logic [DIM_W-1:0] geo_cols = 9'd256;
  longint           geo_cos  = 16384;
  longint           geo_sin  = 0;
  bit               was_written [MEM_DEPTH];

  int burst_left    = 0;
  bit hold_off_req  = 1'b0;
  bit hold_off_done = 1'b0;

  nnrot_in_if  in_ch ();
  nnrot_out_if out_ch ();

  nearest_neighbour_image_rotation_core uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_i        (in_ch),
    .out_o       (out_ch)
  );

  nnrot_rotation_monitor rot_monitor (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending_words)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int rows_now();
    return (geo_rows > MAX_ROWS) ? MAX_ROWS : int'(geo_rows);
  endfunction

  function automatic int cols_now();
    return (geo_cols > MAX_COLS) ? MAX_COLS : int'(geo_cols);
  endfunction

  // where a query lands in the frame, so its source can be written first
  function automatic bit maps_inside(input logic [COORD_W-1:0] row,
                                     input logic [COORD_W-1:0] col,
                                     output int src_row, output int src_col);
    longint nr;
    longint nc;
    longint x2;
    longint y2;
    nr = rows_now();
    nc = cols_now();
    x2 = 2 * longint'(col) - nc;
    y2 = 2 * longint'(row) - nr;
    src_col = int'((x2 * geo_cos + y2 * geo_sin + nc * 16384) / 32768);
    src_row = int'((y2 * geo_cos - x2 * geo_sin + nr * 16384) / 32768);
    return src_row >= 0 && src_row < nr && src_col >= 0 && src_col < nc;
  endfunction

  function automatic logic [COORD_W-1:0] pick_coord(input int limit);
    if (limit == 0 || $urandom_range(0, 5) == 0) begin
      return COORD_W'($urandom_range(0, 255));
    end
    return COORD_W'($urandom_range(0, limit - 1));
  endfunction

  function automatic logic [DIM_W-1:0] rand_dim();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick == 0) begin
      return 9'd256;
    end else if (pick == 1) begin
      return DIM_W'($urandom_range(257, 511));
    end
    return DIM_W'($urandom_range(1, 24));
  endfunction

  function automatic logic [TRIG_W-1:0] rand_trig();
    if ($urandom_range(0, 3) == 0) begin
      return TRIG_W'($urandom);
    end
    return TRIG_W'($urandom_range(0, 32768) - 16384);
  endfunction

  // offers one word, with a random gap whenever a burst runs out
  task automatic offer(input logic kind, input logic [COORD_W-1:0] row,
                       input logic [COORD_W-1:0] col, input logic [VALUE_W-1:0] value);
    int gap;
    if (burst_left == 0) begin
      gap        = $urandom_range(1, 12);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150) : $urandom_range(1, 24);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    burst_left--;
    in_ch.valid <= 1'b1;
    in_ch.kind  <= kind;
    in_ch.row   <= row;
    in_ch.col   <= col;
    in_ch.value <= value;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic offer_write(input logic [COORD_W-1:0] row, input logic [COORD_W-1:0] col,
                             input logic [VALUE_W-1:0] value);
    offer(KIND_WRITE, row, col, value);
    if (int'(row) < rows_now() && int'(col) < cols_now()) begin
      was_written[int'(row) * MAX_COLS + int'(col)] = 1'b1;
    end
  endtask

  task automatic offer_query(input logic [COORD_W-1:0] row, input logic [COORD_W-1:0] col);
    int src_row;
    int src_col;
    if (maps_inside(row, col, src_row, src_col) && !was_written[src_row * MAX_COLS + src_col])
    begin
      offer_write(COORD_W'(src_row), COORD_W'(src_col), VALUE_W'($urandom));
    end
    offer(KIND_QUERY, row, col, VALUE_W'($urandom));
  endtask

  // waits until every query word is back, then lets trailing writes clear the pipe
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_words != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_geometry(input logic [DIM_W-1:0] rows, input logic [DIM_W-1:0] cols,
                              input logic [TRIG_W-1:0] cos_v, input logic [TRIG_W-1:0] sin_v);
    logic [CFG_DATA_W-1:0] data_words [4];
    logic [CFG_IDX_W-1:0]  reg_idx [4];
    // junk above bit 8 of the size registers must be dropped
    data_words[0] = CFG_DATA_W'($urandom);
    data_words[0][DIM_W-1:0] = rows;
    data_words[1] = CFG_DATA_W'($urandom);
    data_words[1][DIM_W-1:0] = cols;
    data_words[2] = cos_v;
    data_words[3] = sin_v;
    reg_idx = '{CFG_ROWS, CFG_COLS, CFG_COS, CFG_SIN};
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= reg_idx[i];
      cfg_data  <= data_words[i];
      @(posedge clk);
    end
    cfg_we   <= 1'b0;
    geo_rows = rows;
    geo_cols = cols;
    geo_cos  = longint'($signed(cos_v));
    geo_sin  = longint'($signed(sin_v));
  endtask

  // result side: open runs, short stalls, and one long hold-off on request
  initial begin : result_sink
    int open_len;
    int stall_len;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_off_req && !hold_off_done) begin
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_off_done = 1'b1;
      end
      open_len  = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 20);
      stall_len = $urandom_range(0, 9);
      out_ch.ready <= 1'b1;
      for (int i = 0; i < open_len; i++) begin
        @(posedge clk);
        if (hold_off_req && !hold_off_done) break;
      end
      if (stall_len != 0 && !(hold_off_req && !hold_off_done)) begin
        out_ch.ready <= 1'b0;
        repeat (stall_len) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    rst_n       <= 1'b0;
    cfg_we      <= 1'b0;
    cfg_index   <= CFG_ROWS;
    cfg_data    <= '0;
    in_ch.valid <= 1'b0;
    in_ch.kind  <= KIND_WRITE;
    in_ch.row   <= '0;
    in_ch.col   <= '0;
    in_ch.value <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset geometry is the identity on a full frame: corners and extreme values
    offer_write(8'd0, 8'd0, 16'h0000);
    offer_write(8'd255, 8'd255, 16'hFFFF);
    offer_write(8'd0, 8'd255, 16'hA5A5);
    offer_write(8'd255, 8'd0, 16'h5A5A);
    offer_query(8'd0, 8'd0);
    offer_query(8'd255, 8'd255);
    offer_query(8'd0, 8'd255);
    offer_query(8'd255, 8'd0);
    settle();

    // 4x4 with a sheared map: row 1 col 0 lands at column minus a half, read as column 0
    set_geometry(9'd4, 9'd4, 16'd16384, 16'd8192);
    offer_write(8'd4, 8'd0, 16'h1234);
    offer_write(8'd0, 8'd4, 16'h4321);
    offer_query(8'd1, 8'd0);
    offer_query(8'd0, 8'd0);
    offer_query(8'd3, 8'd3);
    offer_query(8'd200, 8'd17);
    settle();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: set_geometry(9'd1, 9'd1, rand_trig(), rand_trig());
        1: set_geometry(9'd256, 9'd256, 16'd0, 16'd16384);
        2: set_geometry(9'd256, 9'd256, 16'hC000, 16'd0);
        3: set_geometry(9'h1FF, 9'd257, 16'd11585, 16'd11585);
        4: set_geometry(9'd0, 9'd17, rand_trig(), rand_trig());
        5: set_geometry(9'd12, 9'd0, rand_trig(), rand_trig());
        6: set_geometry(9'd9, 9'd7, 16'h8000, 16'h7FFF);
        default: set_geometry(rand_dim(), rand_dim(), rand_trig(), rand_trig());
      endcase
      if (p == 2) begin
        // keep offering while the result side is held off so the input backs up
        burst_left   = 400;
        hold_off_req = 1'b1;
      end
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if ($urandom_range(0, 9) < 3) begin
          offer_write(pick_coord(rows_now()), pick_coord(cols_now()), VALUE_W'($urandom));
        end else begin
          offer_query(pick_coord(rows_now()), pick_coord(cols_now()));
        end
      end
      settle();
    end

    if (fail_count == 0 && pending_words == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
